// ===== sv/ole_pkg.sv =====
// Package for the ordered list engine: sizes, operation codes and the
// command record passed from the front end to the execution back end.
// No dependencies.
`default_nettype none

package ole_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              pos_ok;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/ole_front.sv =====
// Front end of the ordered list engine: takes input requests, decodes the
// operation and flags positions outside the store. Uses ole_pkg.
`default_nettype none

module ole_front
  import ole_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] data_value,
  input  wire logic [POS_W-1:0]   position,
  output logic                    push,
  output cmd_t                    push_cmd,
  input  wire logic               q_ready
);

  logic f_valid;
  cmd_t f_cmd;
  cmd_t dec_cmd;
  logic accept;

  assign in_stall = f_valid && !q_ready;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && q_ready;
  assign push_cmd = f_cmd;

  always_comb begin
    dec_cmd.value  = data_value;
    dec_cmd.pos    = position;
    // a position at or beyond the store size can never be valid
    dec_cmd.pos_ok = CMP_W'(position) < CMP_W'(DEPTH);
    unique case (mode)
      OP_APPEND: dec_cmd.op = OP_APPEND;
      OP_INSERT: dec_cmd.op = OP_INSERT;
      OP_REMOVE: dec_cmd.op = OP_REMOVE;
      default:   dec_cmd.op = OP_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ole_queue.sv =====
// Two-entry command queue between front end and back end of the ordered
// list engine. Uses ole_pkg for the command record.
`default_nettype none

module ole_queue
  import ole_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      q_ready,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_ready = fill != 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && q_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((push && q_ready) && !(pop && q_valid)) begin
        fill <= fill + 2'd1;
      end else if (!(push && q_ready) && (pop && q_valid)) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && q_ready) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ole_back.sv =====
// Back end of the ordered list engine: the chain of list cells, the match
// compare, the element count and the result register. Uses ole_pkg.
`default_nettype none

module ole_back
  import ole_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire cmd_t         q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              ok,
  output logic [COUNT_W-1:0] count
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t           state;
  logic [VAL_W-1:0] cells [DEPTH];
  logic [DEPTH-1:0] match;
  cmd_t             cmd;
  logic [CNT_W-1:0] elem_cnt;

  logic [DEPTH-1:0] at_or_after;
  logic             any_match;
  logic             full;
  logic [CMP_W-1:0] tgt;
  logic             ins_ok;
  logic             go;
  logic             ok_next;
  logic [CNT_W-1:0] cnt_next;

  assign pop = (state == S_IDLE) && q_valid;
  assign go  = (state == S_APPLY) && (!out_valid || !out_stall);

  always_comb begin
    full = elem_cnt == CNT_W'(DEPTH);
    // append is an insert at the tail
    tgt = (cmd.op == OP_APPEND) ? CMP_W'(elem_cnt) : CMP_W'(cmd.pos);
    ins_ok = !full && ((cmd.op == OP_APPEND) ||
                       (cmd.pos_ok && (tgt <= CMP_W'(elem_cnt))));
    at_or_after[0] = match[0];
    for (int i = 1; i < DEPTH; i++) begin
      at_or_after[i] = at_or_after[i-1] | match[i];
    end
    any_match = at_or_after[DEPTH-1];

    case (cmd.op) inside
      OP_APPEND, OP_INSERT: begin
        ok_next  = ins_ok;
        cnt_next = ins_ok ? elem_cnt + CNT_W'(1) : elem_cnt;
      end
      OP_REMOVE: begin
        ok_next  = any_match;
        cnt_next = any_match ? elem_cnt - CNT_W'(1) : elem_cnt;
      end
      default: begin
        ok_next  = 1'b1;
        cnt_next = '0;
      end
    endcase
  end

  // state, element count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      elem_cnt  <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (go) begin
            state     <= S_IDLE;
            ok        <= ok_next;
            count     <= COUNT_W'(cnt_next);
            elem_cnt  <= cnt_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cell chain: compare on load, shift on apply
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
      for (int i = 0; i < DEPTH; i++) begin
        match[i] <= (cells[i] == q_cmd.value) && (CMP_W'(i) < CMP_W'(elem_cnt));
      end
    end
    if (go) begin
      case (cmd.op) inside
        OP_APPEND, OP_INSERT: begin
          if (ins_ok) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CMP_W'(i) == tgt) begin
                cells[i] <= cmd.value;
              end
            end
            for (int i = 1; i < DEPTH; i++) begin
              if (CMP_W'(i) > tgt) begin
                cells[i] <= cells[i-1];
              end
            end
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (at_or_after[i]) begin
              cells[i] <= cells[i+1];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ordered_list_engine_unit.sv =====
// Ordered list engine: bounded ordered list of signed 32-bit words.
// Depends on ole_pkg, ole_front, ole_queue and ole_back.
// Usage:
//   Input channel (in_valid / in_stall) carries one request: mode selects
//   append (0), insert at position (1), remove first match of data_value
//   (2) or clear (3). A request is taken at a rising edge with in_valid
//   high and in_stall low.
//   Output channel (out_valid / out_stall) returns one result per request:
//   ok flags success, count is the element count after the operation
//   (low 5 bits). Full list, insert position beyond the count and remove
//   with no match give ok = 0 and leave the list unchanged.
//   A request passes from accept to result valid through the front end
//   register, the queue write, the compare and the apply. The back end
//   takes a new request only after it has applied the last one: it compares
//   all cells on load and shifts the cell chain on apply.
//   The front end keeps accepting into a two-entry queue while the back end
//   works or waits; a held result in the output register stalls the back
//   end, and the front end stalls once the queue is full.
//   Reset (rst, synchronous) empties the list, the queue and the output
//   register; cell contents are not cleared.
`default_nettype none

module ordered_list_engine_unit
  import ole_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] data_value,
  input  wire logic [POS_W-1:0]   position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    ok,
  output logic [COUNT_W-1:0]      count
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_ready;

  // queue to back end
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  // decode and hold one request
  ole_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .data_value (data_value),
    .position   (position),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_ready    (q_ready)
  );

  // decouple front and back
  ole_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // execute against the cell chain and register the result
  ole_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .count     (count)
  );

endmodule

`default_nettype wire

// ===== sv/ole_checker.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
// Uses ole_pkg for the list depth.
`default_nettype none

module ole_checker
  import ole_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               ok,
  input wire logic [COUNT_W-1:0] count
);

  logic               out_take;
  logic               have_last;
  logic [COUNT_W-1:0] last_cnt;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      last_cnt  <= '0;
    end else if (out_take) begin
      have_last <= 1'b1;
      last_cnt  <= count;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ok) && $stable(count))
    else $error("stalled result changed");

  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    out_take && !ok && have_last |-> count == last_cnt)
    else $error("failed request changed the count");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_take && ok && have_last |->
      (count == '0) || (count == last_cnt + COUNT_W'(1)) ||
      (count == last_cnt - COUNT_W'(1)))
    else $error("count moved by more than one");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (count <= COUNT_W'(DEPTH)))
    else $error("count above list depth");

endmodule

bind ordered_list_engine_unit ole_checker u_ole_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ok        (ok),
  .count     (count)
);

`default_nettype wire
